>>> hw/rtl/mad_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus ADU deframer.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package mad_pkg;

  localparam int unsigned MAX_FRAME_DEF = 512;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned DATA_W  = 40;
  localparam int unsigned ADDR_W  = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CRC      = 3'd2,
    ST_LEN      = 3'd3,
    ST_OVERLONG = 3'd4
  } mad_status_t;

  typedef enum logic {
    TR_RTU = 1'b0,
    TR_TCP = 1'b1
  } mad_transport_t;

  localparam logic [ADDR_W-3:0] REG_TRANSPORT = 1'b0;

  // One queue entry: all results caused by one input beat.
  typedef struct packed {
    logic        has_pdu;
    logic        has_sum;
    logic [7:0]  pdu_byte;
    logic [7:0]  unit_id;
    mad_status_t status;
    logic [15:0] pdu_length;
  } mad_entry_t;

  // Reflected CRC-16, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mad_front.sv
// Front end: accepts frame bytes, tracks frame state and CRC, builds queue entries.
// Depends on mad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mad_front #(
  parameter int unsigned MAX_FRAME = mad_pkg::MAX_FRAME_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                transport,
  input  wire logic                clr,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_end,
  input  wire logic                q_full,
  output logic                     in_ready,
  output logic                     push,
  output mad_pkg::mad_entry_t      entry
);
  import mad_pkg::*;

  localparam int unsigned IW = $clog2(MAX_FRAME + 1);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = (LW > 17) ? LW : 17;

  logic [IW-1:0] byte_index;
  logic [15:0]   crc_accum;
  logic [7:0]    held0;
  logic [7:0]    held1;
  logic [7:0]    seen_unit;
  logic [15:0]   header_length;
  logic          overlong_flag;

  logic [IW-1:0] byte_index_next;
  logic [15:0]   crc_next;
  logic [7:0]    unit_next;
  logic [15:0]   hl_next;
  logic          ovf;
  logic          ovl;
  logic [CW-1:0] p_c;
  logic [CW-1:0] len;
  logic [CW-1:0] hl_c;
  logic [CW-1:0] rtu_plen;
  logic [CW-1:0] tcp_a;
  logic [CW-1:0] tcp_c;
  logic          accept;
  mad_entry_t    e;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign ovf = (byte_index == IW'(MAX_FRAME));
  assign ovl = overlong_flag || ovf;
  assign byte_index_next = ovf ? byte_index : byte_index + IW'(1);
  assign p_c  = CW'(byte_index);
  assign len  = p_c + CW'(1);

  always_comb begin
    crc_next  = crc_accum;
    unit_next = seen_unit;
    hl_next   = header_length;
    e         = '0;
    e.pdu_byte = 8'h00;
    rtu_plen  = '0;
    tcp_a     = p_c - CW'(6);
    tcp_c     = '0;
    hl_c      = '0;
    if (transport == TR_RTU) begin
      if (byte_index == '0) unit_next = in_byte;
      if (byte_index >= IW'(2)) crc_next = crc16_byte(crc_accum, held0);
      if (byte_index >= IW'(3)) begin
        e.has_pdu  = 1'b1;
        e.pdu_byte = held0;
      end
      if (ovl) e.status = ST_OVERLONG;
      else if (len < CW'(4)) e.status = ST_SHORT;
      else if (crc_next != {in_byte, held1}) e.status = ST_CRC;
      else e.status = ST_OK;
      rtu_plen = len - CW'(3);
      if (!ovl && len >= CW'(3)) begin
        e.pdu_length = (rtu_plen > CW'(16'hFFFF)) ? 16'hFFFF : rtu_plen[15:0];
      end
    end else begin
      if (byte_index == IW'(4)) hl_next = {in_byte, header_length[7:0]};
      else if (byte_index == IW'(5)) hl_next = {header_length[15:8], in_byte};
      else if (byte_index == IW'(6)) unit_next = in_byte;
      hl_c  = CW'(hl_next);
      tcp_c = hl_c - CW'(1);
      if (p_c >= CW'(7) && hl_c >= CW'(2) && p_c <= hl_c + CW'(5)) begin
        e.has_pdu  = 1'b1;
        e.pdu_byte = in_byte;
      end
      if (ovl) e.status = ST_OVERLONG;
      else if (len < CW'(8)) e.status = ST_SHORT;
      else if (hl_c < CW'(1) || len < hl_c + CW'(6)) e.status = ST_LEN;
      else e.status = ST_OK;
      if (!ovl && p_c >= CW'(7) && hl_c >= CW'(2)) begin
        e.pdu_length = (tcp_a < tcp_c) ? tcp_a[15:0] : tcp_c[15:0];
      end
    end
    e.has_sum = in_end;
    e.unit_id = unit_next;
    if (!in_end) begin
      e.status     = ST_OK;
      e.pdu_length = '0;
      e.unit_id    = '0;
    end
  end

  assign push  = accept && (e.has_pdu || e.has_sum);
  assign entry = e;

  always_ff @(posedge clk) begin
    if (rst || clr || (accept && in_end)) begin
      byte_index    <= '0;
      crc_accum     <= CRC_INIT;
      held0         <= '0;
      held1         <= '0;
      seen_unit     <= '0;
      header_length <= '0;
      overlong_flag <= 1'b0;
    end else if (accept) begin
      byte_index    <= byte_index_next;
      crc_accum     <= crc_next;
      held0         <= held1;
      held1         <= in_byte;
      seen_unit     <= unit_next;
      header_length <= hl_next;
      overlong_flag <= ovl;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mad_queue.sv
// Two-entry queue of result entries between front and back ends.
// Depends on mad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mad_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire mad_pkg::mad_entry_t wr_entry,
  input  wire logic                pop,
  output logic                     full,
  output logic                     not_empty,
  output mad_pkg::mad_entry_t      rd_entry
);
  import mad_pkg::*;

  mad_entry_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mad_back.sv
// Back end: expands queue entries into output beats, PDU byte before summary.
// Depends on mad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mad_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire mad_pkg::mad_entry_t    q_entry,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [mad_pkg::DATA_W-1:0]  m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);
  import mad_pkg::*;

  mad_entry_t cur;
  logic       cur_valid;
  logic       phase;
  logic       sum_now;
  logic       done;

  assign sum_now = cur.has_sum && (phase || !cur.has_pdu);
  assign done    = cur_valid && m_tready && (phase || !(cur.has_pdu && cur.has_sum));
  assign q_pop   = q_valid && (!cur_valid || done);

  assign m_tvalid = cur_valid;
  assign m_tuser  = sum_now;
  assign m_tlast  = sum_now || !cur.has_sum;
  assign m_tdata  = sum_now
                  ? DATA_W'({cur.pdu_length, cur.status, cur.unit_id, 8'h00})
                  : DATA_W'(cur.pdu_byte);

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (cur_valid && m_tready) begin
      phase     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/modbus_adu_deframer_core.sv
// Modbus ADU deframer top level: APB register, front end, queue and back end.
// Depends on mad_pkg, mad_front, mad_queue, mad_back.
// A result beat is held in a queue slot, then in the back-end entry register.
// Throughput: one input beat per cycle while the queue is not full; a final beat
// also releasing a PDU byte needs two output beats; the output side sets the pace.
// Reset: synchronous rst clears frame state and queue; transport returns to RTU.
`timescale 1ns / 1ps
`default_nettype none

module modbus_adu_deframer_core #(
  parameter int unsigned MAX_FRAME = mad_pkg::MAX_FRAME_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mad_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // frame_byte
  input  wire logic                         s_tlast,   // frame_end
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // pdu_byte [7:0], unit_id [15:8], status [18:16], pdu_length [34:19], zero fill
  output logic [mad_pkg::DATA_W-1:0]        m_tdata,
  output logic                              m_tuser,   // is_status
  output logic                              m_tlast    // last
);
  import mad_pkg::*;

  logic       transport;
  logic       cfg_wr;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  mad_entry_t wr_entry;
  mad_entry_t rd_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[ADDR_W-1:2] == REG_TRANSPORT);
  assign prdata = (paddr[ADDR_W-1:2] == REG_TRANSPORT) ? {31'd0, transport} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      transport <= TR_RTU;
    end else if (cfg_wr) begin
      transport <= pwdata[0];
    end
  end

  mad_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk      (clk),
    .rst      (rst),
    .transport(transport),
    .clr      (cfg_wr),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .entry    (wr_entry)
  );

  mad_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_valid),
    .rd_entry (rd_entry)
  );

  mad_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .q_pop   (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  a_sum_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("summary beat without last");

  a_pdu_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[DATA_W-1:8] == '0))
    else $error("PDU beat carries summary fields");

  a_overlong_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (m_tdata[18:16] == ST_OVERLONG)) |-> (m_tdata[34:19] == 16'd0))
    else $error("overlong summary with nonzero length");

endmodule

`default_nettype wire
